// ===== hw/rtl/scba_pkg.sv =====
// Shared types and constants for the size-class block allocator.
package scba_pkg;

	localparam int BLOCKS_PER_CLASS_DEF = 16;
	localparam int NUM_CLASSES_DEF      = 8;
	localparam int TAG_WIDTH_DEF        = 32;

	// Widest internal fields over the whole parameter range
	localparam int CLS_MAX_W = 4;
	localparam int IDX_MAX_W = 6;
	localparam int TAG_MAX_W = 64;

	localparam int SIZE_W       = 10;
	localparam int IN_TAG_W     = 32;
	localparam int CLASS_PORT_W = 3;
	localparam int INDEX_PORT_W = 4;
	localparam int STATUS_W     = 2;

	localparam int MIN_BLOCK_BYTES = 4;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_FAIL  = 2'd2
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [CLS_MAX_W-1:0] cls;
		logic [IDX_MAX_W-1:0] idx;
		logic [TAG_MAX_W-1:0] tag;
	} cmd_t;

endpackage

// ===== hw/rtl/scba_front.sv =====
// Front end: classifies a request word into an allocate, free or failed command.
module scba_front #(
	parameter int NUM_CLASSES      = scba_pkg::NUM_CLASSES_DEF,
	parameter int BLOCKS_PER_CLASS = scba_pkg::BLOCKS_PER_CLASS_DEF,
	parameter int TAG_WIDTH        = scba_pkg::TAG_WIDTH_DEF
) (
	input  logic                                cmd,
	input  logic [scba_pkg::SIZE_W-1:0]         request_size,
	input  logic [scba_pkg::IN_TAG_W-1:0]       owner_tag,
	input  logic [scba_pkg::CLASS_PORT_W-1:0]   free_class,
	input  logic [scba_pkg::INDEX_PORT_W-1:0]   free_index,
	output scba_pkg::cmd_t                      word
);

	localparam logic [scba_pkg::TAG_MAX_W-1:0] TAG_MASK =
		scba_pkg::TAG_MAX_W'((65'd1 << TAG_WIDTH) - 65'd1);

	logic                             found;
	logic [scba_pkg::CLS_MAX_W-1:0]   size_cls;

	// Smallest class whose block holds the size
	always_comb begin
		found    = 1'b0;
		size_cls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (16'(request_size) <= (16'(scba_pkg::MIN_BLOCK_BYTES) << c)) begin
				found    = 1'b1;
				size_cls = scba_pkg::CLS_MAX_W'(c);
			end
		end
		if (request_size == '0) begin
			found = 1'b0;
		end
	end

	always_comb begin
		word = '0;
		if (cmd == scba_pkg::CMD_FREE) begin
			word.cls = scba_pkg::CLS_MAX_W'(free_class);
			word.idx = scba_pkg::IDX_MAX_W'(free_index);
			if (int'(free_class) < NUM_CLASSES && int'(free_index) < BLOCKS_PER_CLASS) begin
				word.op = scba_pkg::OP_FREE;
			end else begin
				word.op = scba_pkg::OP_FAIL;
			end
		end else if (found) begin
			word.op  = scba_pkg::OP_ALLOC;
			word.cls = size_cls;
			word.tag = scba_pkg::TAG_MAX_W'(owner_tag) & TAG_MASK;
		end else begin
			word.op = scba_pkg::OP_FAIL;
		end
	end

endmodule

// ===== hw/rtl/scba_queue.sv =====
// Two-entry command queue between the front end and the back end.
module scba_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  scba_pkg::cmd_t  push_word,
	output logic            pop_valid,
	input  logic            pop_ready,
	output scba_pkg::cmd_t  pop_word
);

	localparam int PTR_W = (scba_pkg::QUEUE_DEPTH > 1) ? $clog2(scba_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(scba_pkg::QUEUE_DEPTH + 1);

	scba_pkg::cmd_t     mem_q [scba_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = count_q != CNT_W'(scba_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_word   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(scba_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(scba_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ===== hw/rtl/scba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/scba_back.sv =====
// Back end: free-mark table, first-free search, tag store and result register.
module scba_back #(
	parameter int NUM_CLASSES      = scba_pkg::NUM_CLASSES_DEF,
	parameter int BLOCKS_PER_CLASS = scba_pkg::BLOCKS_PER_CLASS_DEF,
	parameter int TAG_WIDTH        = scba_pkg::TAG_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  scba_pkg::cmd_t                     pop_word,
	output logic                               clearing,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [scba_pkg::STATUS_W-1:0]      status,
	output logic [scba_pkg::CLASS_PORT_W-1:0]  block_class,
	output logic [scba_pkg::INDEX_PORT_W-1:0]  block_index
);

	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int IDX_W  = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
	localparam int DEPTH  = NUM_CLASSES * BLOCKS_PER_CLASS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	logic [BLOCKS_PER_CLASS-1:0]        marks_q [NUM_CLASSES];
	logic [CNT_W-1:0]                   clr_cnt_q;
	logic                               out_valid_q;
	logic [scba_pkg::STATUS_W-1:0]      status_q;
	logic [scba_pkg::CLASS_PORT_W-1:0]  block_class_q;
	logic [scba_pkg::INDEX_PORT_W-1:0]  block_index_q;

	logic [CLS_W-1:0]             cls_sel;
	logic [IDX_W-1:0]             idx_sel;
	logic [BLOCKS_PER_CLASS-1:0]  sel_marks;
	logic                         hit;
	logic [IDX_W-1:0]             hit_idx;
	logic [IDX_W-1:0]             wr_idx;
	logic                         take;
	logic                         is_alloc;
	logic                         is_free;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_addr;
	logic [TAG_WIDTH-1:0]         ram_wdata;
	logic [TAG_WIDTH-1:0]         tag_rdata;

	assign clearing  = clr_cnt_q != CNT_W'(DEPTH);
	assign pop_ready = !clearing && (!out_valid_q || out_ready);
	assign take      = pop_valid && pop_ready;
	assign is_alloc  = pop_word.op == scba_pkg::OP_ALLOC;
	assign is_free   = pop_word.op == scba_pkg::OP_FREE;
	assign cls_sel   = pop_word.cls[CLS_W-1:0];
	assign idx_sel   = pop_word.idx[IDX_W-1:0];
	assign sel_marks = marks_q[cls_sel];

	// Lowest-numbered free block of the chosen class
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = BLOCKS_PER_CLASS - 1; i >= 0; i--) begin
			if (sel_marks[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign wr_idx = is_alloc ? hit_idx : idx_sel;

	// Tag store: swept to zero after reset, then written on grant and free
	always_comb begin
		if (clearing) begin
			ram_we    = 1'b1;
			ram_addr  = clr_cnt_q[ADDR_W-1:0];
			ram_wdata = '0;
		end else begin
			ram_we    = take && ((is_alloc && hit) || is_free);
			ram_addr  = ADDR_W'(int'(cls_sel) * BLOCKS_PER_CLASS + int'(wr_idx));
			ram_wdata = is_free ? '0 : pop_word.tag[TAG_WIDTH-1:0];
		end
	end

	scba_ram #(
		.WIDTH (TAG_WIDTH),
		.DEPTH (DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.raddr (ram_addr),
		.rdata (tag_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				marks_q[c] <= '1;
			end
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (take) begin
				if (is_alloc && hit) begin
					marks_q[cls_sel][hit_idx] <= 1'b0;
				end else if (is_free) begin
					marks_q[cls_sel][idx_sel] <= 1'b1;
				end
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			block_class_q <= pop_word.cls[scba_pkg::CLASS_PORT_W-1:0];
			if (pop_word.op == scba_pkg::OP_FAIL) begin
				status_q      <= scba_pkg::ST_RANGE;
				block_index_q <= pop_word.idx[scba_pkg::INDEX_PORT_W-1:0];
			end else if (is_alloc) begin
				status_q      <= hit ? scba_pkg::ST_OK : scba_pkg::ST_FULL;
				block_index_q <= hit ? scba_pkg::INDEX_PORT_W'(hit_idx) : '0;
			end else begin
				status_q      <= scba_pkg::ST_OK;
				block_index_q <= pop_word.idx[scba_pkg::INDEX_PORT_W-1:0];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign block_class = block_class_q;
	assign block_index = block_index_q;

endmodule

// ===== hw/rtl/size_class_block_allocator.sv =====
// Top level of the size-class block allocator.
//
//   channel  direction  handshake              payload
//   request  in         in_valid / in_ready    cmd, request_size, owner_tag,
//                                              free_class, free_index
//   result   out        out_valid / out_ready  status, block_class, block_index
//
// One word is accepted per cycle when the result side keeps up; its result
// is registered first in the queue and then in the result register,
// with one result for every request.
// The per-class first-free search and mark update run in the same back-end cycle.
// After reset the tag store is swept to zero over its NUM_CLASSES * BLOCKS_PER_CLASS
// entries (128 by default); in_ready stays low during the sweep.
// A stalled result holds in the output register while the two-entry queue
// keeps taking requests until it fills.
module size_class_block_allocator #(
	parameter int NUM_CLASSES      = scba_pkg::NUM_CLASSES_DEF,
	parameter int BLOCKS_PER_CLASS = scba_pkg::BLOCKS_PER_CLASS_DEF,
	parameter int TAG_WIDTH        = scba_pkg::TAG_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [scba_pkg::SIZE_W-1:0]        request_size,
	input  logic [scba_pkg::IN_TAG_W-1:0]      owner_tag,
	input  logic [scba_pkg::CLASS_PORT_W-1:0]  free_class,
	input  logic [scba_pkg::INDEX_PORT_W-1:0]  free_index,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [scba_pkg::STATUS_W-1:0]      status,
	output logic [scba_pkg::CLASS_PORT_W-1:0]  block_class,
	output logic [scba_pkg::INDEX_PORT_W-1:0]  block_index
);

	scba_pkg::cmd_t  front_word;
	scba_pkg::cmd_t  queue_word;
	logic            push_ready;
	logic            queue_valid;
	logic            queue_ready;
	logic            clearing;

	assign in_ready = push_ready && !clearing;

	scba_front #(
		.NUM_CLASSES      (NUM_CLASSES),
		.BLOCKS_PER_CLASS (BLOCKS_PER_CLASS),
		.TAG_WIDTH        (TAG_WIDTH)
	) u_front (
		.cmd          (cmd),
		.request_size (request_size),
		.owner_tag    (owner_tag),
		.free_class   (free_class),
		.free_index   (free_index),
		.word         (front_word)
	);

	scba_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid && !clearing),
		.push_ready (push_ready),
		.push_word  (front_word),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_word   (queue_word)
	);

	scba_back #(
		.NUM_CLASSES      (NUM_CLASSES),
		.BLOCKS_PER_CLASS (BLOCKS_PER_CLASS),
		.TAG_WIDTH        (TAG_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (queue_valid),
		.pop_ready   (queue_ready),
		.pop_word    (queue_word),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.block_class (block_class),
		.block_index (block_index)
	);

endmodule

// ===== hw/rtl/scba_checker.sv =====
// Port-level checks for the size-class block allocator, bound to the top level.
module scba_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [scba_pkg::STATUS_W-1:0]      status,
	input logic [scba_pkg::CLASS_PORT_W-1:0]  block_class,
	input logic [scba_pkg::INDEX_PORT_W-1:0]  block_index
);

	logic [3:0] inflight_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// Count words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_take && !out_take) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_take && !in_take) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(block_class) && $stable(block_index))
		else $error("result changed while stalled");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result with no request outstanding");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == scba_pkg::ST_OK || status == scba_pkg::ST_RANGE ||
			status == scba_pkg::ST_FULL)
		else $error("undefined status code");

	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == scba_pkg::ST_FULL |-> block_index == '0)
		else $error("full class reported a nonzero index");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.block_class (block_class),
	.block_index (block_index)
);
